/* rtl/core/bpa_pkg.sv */
// bpa_pkg: shared types, codes and helpers of the buddy page allocator
// no dependencies; imported by the allocator core and its checker
`default_nettype none

package bpa_pkg;

    // pool geometry
    localparam int NUM_PAGES = 4096;
    localparam int TOP_ORDER = 10;
    localparam int PAGE_W    = 12;
    localparam int LINK_W    = 13;
    localparam int ORDER_W   = 4;
    localparam int NUM_LISTS = TOP_ORDER + 1;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_PAGES);

    // page kinds
    localparam logic [1:0] KIND_FREE_TAIL  = 2'd0;
    localparam logic [1:0] KIND_FREE_HEAD  = 2'd1;
    localparam logic [1:0] KIND_ALLOC_HEAD = 2'd2;
    localparam logic [1:0] KIND_USED       = 2'd3;

    // request codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;
    localparam logic [1:0] OP_BUILD   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // one page entry of the metadata memory
    typedef struct packed {
        logic [1:0]         kind;
        logic [ORDER_W-1:0] blk_order;
        logic [LINK_W-1:0]  next_link;
        logic [LINK_W-1:0]  prev_link;
    } meta_t;

    // index of the highest set bit, zero for zero
    function automatic logic [ORDER_W-1:0] flog2(input logic [LINK_W-1:0] v);
        logic [ORDER_W-1:0] r;
        r = '0;
        for (int i = 0; i < LINK_W; i++)
        begin
            if (v[i])
            begin
                r = ORDER_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/buddy_page_allocator_core.sv */
// buddy_page_allocator_core: binary buddy allocator over a 4096 page pool
// depends on bpa_pkg; metadata and reserved map live in on-chip memories
`default_nettype none

// One request word in, one result word out. The block holds one request at
// a time and walks a single-port page metadata memory with a registered
// read, so every list link update is a read then a write. Alloc walks one
// split level per pass; free walks one merged level per pass and ends with
// a tail insert. Reserve writes the reserved map at one page per cycle.
// Build scans page by page (pages ahead of a reserved page are scanned
// again for each smaller block cut in front of it) and ends each block with
// a tail insert. After reset a clearing pass zeroes the reserved map; no
// request word is taken during it, configuration writes are.
module buddy_page_allocator_core
    import bpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [12:0] cfg_wr_data,   // pages_in_use
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // op, block_order, page_index, page_count
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata   // status, result_page, result_order
);

    // state codes
    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DONE    = 5'd2;
    localparam logic [4:0] S_U_RD    = 5'd3;
    localparam logic [4:0] S_U_GOT   = 5'd4;
    localparam logic [4:0] S_U_PV    = 5'd5;
    localparam logic [4:0] S_U_NX    = 5'd6;
    localparam logic [4:0] S_U_NXW   = 5'd7;
    localparam logic [4:0] S_P_WR    = 5'd8;
    localparam logic [4:0] S_P_RD    = 5'd9;
    localparam logic [4:0] S_P_LW    = 5'd10;
    localparam logic [4:0] S_A_SPLIT = 5'd11;
    localparam logic [4:0] S_A_FIN   = 5'd12;
    localparam logic [4:0] S_F_CHK   = 5'd13;
    localparam logic [4:0] S_M_TEST  = 5'd14;
    localparam logic [4:0] S_M_CHK   = 5'd15;
    localparam logic [4:0] S_M_JOIN  = 5'd16;
    localparam logic [4:0] S_M_EXIT  = 5'd17;
    localparam logic [4:0] S_M_DONE  = 5'd18;
    localparam logic [4:0] S_RSV     = 5'd19;
    localparam logic [4:0] S_B_START = 5'd20;
    localparam logic [4:0] S_B_SCAN  = 5'd21;
    localparam logic [4:0] S_B_CHK   = 5'd22;

    // input word fields
    logic [1:0]         in_op;
    logic [ORDER_W-1:0] in_order;
    logic [PAGE_W-1:0]  in_page;
    logic [LINK_W-1:0]  in_count;

    assign in_op    = s_axis_tdata[1:0];
    assign in_order = s_axis_tdata[5:2];
    assign in_page  = s_axis_tdata[17:6];
    assign in_count = s_axis_tdata[30:18];

    // memories
    meta_t meta_mem [NUM_PAGES];
    logic  res_mem  [NUM_PAGES];
    meta_t meta_rd_reg;
    logic  res_rd_reg;

    logic [PAGE_W-1:0] meta_addr;
    logic              meta_we;
    meta_t             meta_wdata;
    logic [PAGE_W-1:0] res_addr;
    logic              res_we;
    logic              res_wdata;

    // control and working registers
    logic [4:0]         st_reg, st_next, ret_reg, ret_next;
    logic [ORDER_W-1:0] cur_reg, cur_next, ord_reg, ord_next, fit_reg, fit_next;
    logic [PAGE_W-1:0]  pfn_reg, pfn_next, bud_reg, bud_next;
    logic [PAGE_W-1:0]  tgt_reg, tgt_next, ppg_reg, ppg_next;
    logic [LINK_W-1:0]  pv_reg, pv_next, nx_reg, nx_next;
    logic [LINK_W-1:0]  idx_reg, idx_next, end_reg, end_next, s_reg, s_next;
    logic [LINK_W-1:0]  piu_reg;
    logic [LINK_W-1:0]  first_reg [NUM_LISTS];
    logic [LINK_W-1:0]  first_next [NUM_LISTS];
    logic [LINK_W-1:0]  last_reg [NUM_LISTS];
    logic [LINK_W-1:0]  last_next [NUM_LISTS];
    logic [1:0]         fin_stat_reg, fin_stat_next;
    logic [PAGE_W-1:0]  fin_page_reg, fin_page_next;
    logic [ORDER_W-1:0] fin_ord_reg, fin_ord_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic [1:0]         out_stat_reg;
    logic [PAGE_W-1:0]  out_page_reg;
    logic [ORDER_W-1:0] out_ord_reg;

    // helpers
    logic [LINK_W-1:0]  managed;
    logic               hit;
    logic [ORDER_W-1:0] hit_o;
    logic [ORDER_W-1:0] fit_c;
    logic [PAGE_W-1:0]  bud_c;
    logic [ORDER_W-1:0] split_o;
    logic [LINK_W:0]    rsv_sum;

    assign managed = (piu_reg > LINK_NONE) ? LINK_NONE : piu_reg;

    // lowest non-empty list at or above the requested order
    always_comb
    begin
        hit   = 1'b0;
        hit_o = '0;
        for (int o = TOP_ORDER; o >= 0; o--)
        begin
            if (ORDER_W'(o) >= in_order && !first_reg[o][PAGE_W])
            begin
                hit   = 1'b1;
                hit_o = ORDER_W'(o);
            end
        end
    end

    // largest aligned block at the build cursor that fits the managed range
    always_comb
    begin
        logic [LINK_W-1:0] msk;
        fit_c = '0;
        for (int o = 0; o <= TOP_ORDER; o++)
        begin
            msk = LINK_W'((1 << o) - 1);
            if ((s_reg & msk) == '0 &&
                ({1'b0, s_reg} + (LINK_W+1)'(1 << o)) <= {1'b0, managed})
            begin
                fit_c = ORDER_W'(o);
            end
        end
    end

    assign bud_c   = pfn_reg ^ (PAGE_W'(1) << cur_reg);
    assign split_o = flog2(idx_reg - s_reg);
    assign rsv_sum = {2'b00, in_page} + {1'b0, in_count};

    // sequencer
    always_comb
    begin
        st_next        = st_reg;
        ret_next       = ret_reg;
        cur_next       = cur_reg;
        ord_next       = ord_reg;
        fit_next       = fit_reg;
        pfn_next       = pfn_reg;
        bud_next       = bud_reg;
        tgt_next       = tgt_reg;
        ppg_next       = ppg_reg;
        pv_next        = pv_reg;
        nx_next        = nx_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        s_next         = s_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        fin_stat_next  = fin_stat_reg;
        fin_page_next  = fin_page_reg;
        fin_ord_next   = fin_ord_reg;
        out_load       = 1'b0;
        meta_addr      = tgt_reg;
        meta_we        = 1'b0;
        meta_wdata     = '0;
        res_addr       = idx_reg[PAGE_W-1:0];
        res_we         = 1'b0;
        res_wdata      = 1'b0;

        unique case (st_reg)
            S_CLR:
            begin
                res_we    = 1'b1;
                res_wdata = 1'b0;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LINK_W'(NUM_PAGES - 1))
                begin
                    idx_next = '0;
                    st_next  = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ord_next      = in_order;
                    fin_stat_next = ST_OK;
                    fin_page_next = '0;
                    fin_ord_next  = '0;
                    st_next       = S_DONE;
                    unique case (in_op)
                        OP_ALLOC:
                        begin
                            if (in_order > ORDER_W'(TOP_ORDER))
                            begin
                                fin_stat_next = ST_TOO_BIG;
                            end
                            else if (!hit)
                            begin
                                fin_stat_next = ST_NO_FREE;
                            end
                            else
                            begin
                                cur_next = hit_o;
                                pfn_next = first_reg[hit_o][PAGE_W-1:0];
                                tgt_next = first_reg[hit_o][PAGE_W-1:0];
                                ret_next = S_A_SPLIT;
                                st_next  = S_U_RD;
                            end
                        end
                        OP_FREE:
                        begin
                            if ({1'b0, in_page} >= managed)
                            begin
                                fin_stat_next = ST_IGNORED;
                            end
                            else
                            begin
                                meta_addr = in_page;
                                pfn_next  = in_page;
                                st_next   = S_F_CHK;
                            end
                        end
                        OP_RESERVE:
                        begin
                            if (in_count == '0)
                            begin
                                fin_stat_next = ST_IGNORED;
                            end
                            else
                            begin
                                idx_next = {1'b0, in_page};
                                end_next = (rsv_sum > {1'b0, LINK_NONE}) ? LINK_NONE
                                                                         : rsv_sum[LINK_W-1:0];
                                st_next  = S_RSV;
                            end
                        end
                        OP_BUILD:
                        begin
                            for (int o = 0; o < NUM_LISTS; o++)
                            begin
                                first_next[o] = LINK_NONE;
                                last_next[o]  = LINK_NONE;
                            end
                            s_next  = '0;
                            st_next = S_B_START;
                        end
                        default:
                        begin
                            st_next = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    st_next  = S_IDLE;
                end
            end

            // unlink tgt from list cur
            S_U_RD:
            begin
                meta_addr = tgt_reg;
                st_next   = S_U_GOT;
            end
            S_U_GOT:
            begin
                pv_next = meta_rd_reg.prev_link;
                nx_next = meta_rd_reg.next_link;
                if (!meta_rd_reg.prev_link[PAGE_W])
                begin
                    meta_addr = meta_rd_reg.prev_link[PAGE_W-1:0];
                    st_next   = S_U_PV;
                end
                else
                begin
                    first_next[cur_reg] = meta_rd_reg.next_link;
                    st_next             = S_U_NX;
                end
            end
            S_U_PV:
            begin
                meta_addr            = pv_reg[PAGE_W-1:0];
                meta_we              = 1'b1;
                meta_wdata           = meta_rd_reg;
                meta_wdata.next_link = nx_reg;
                st_next              = S_U_NX;
            end
            S_U_NX:
            begin
                if (!nx_reg[PAGE_W])
                begin
                    meta_addr = nx_reg[PAGE_W-1:0];
                    st_next   = S_U_NXW;
                end
                else
                begin
                    last_next[cur_reg] = pv_reg;
                    st_next            = ret_reg;
                end
            end
            S_U_NXW:
            begin
                meta_addr            = nx_reg[PAGE_W-1:0];
                meta_we              = 1'b1;
                meta_wdata           = meta_rd_reg;
                meta_wdata.prev_link = pv_reg;
                st_next              = ret_reg;
            end

            // push ppg at the tail of list cur
            S_P_WR:
            begin
                meta_addr  = ppg_reg;
                meta_we    = 1'b1;
                meta_wdata = '{kind: KIND_FREE_HEAD, blk_order: cur_reg,
                               next_link: LINK_NONE, prev_link: last_reg[cur_reg]};
                if (!last_reg[cur_reg][PAGE_W])
                begin
                    st_next = S_P_RD;
                end
                else
                begin
                    first_next[cur_reg] = {1'b0, ppg_reg};
                    last_next[cur_reg]  = {1'b0, ppg_reg};
                    st_next             = ret_reg;
                end
            end
            S_P_RD:
            begin
                meta_addr = last_reg[cur_reg][PAGE_W-1:0];
                st_next   = S_P_LW;
            end
            S_P_LW:
            begin
                meta_addr            = last_reg[cur_reg][PAGE_W-1:0];
                meta_we              = 1'b1;
                meta_wdata           = meta_rd_reg;
                meta_wdata.next_link = {1'b0, ppg_reg};
                last_next[cur_reg]   = {1'b0, ppg_reg};
                st_next              = ret_reg;
            end

            // alloc: split down one level per pass
            S_A_SPLIT:
            begin
                if (cur_reg > ord_reg)
                begin
                    cur_next = cur_reg - 1'b1;
                    ppg_next = pfn_reg + (PAGE_W'(1) << (cur_reg - 1'b1));
                    ret_next = S_A_SPLIT;
                    st_next  = S_P_WR;
                end
                else
                begin
                    st_next = S_A_FIN;
                end
            end
            S_A_FIN:
            begin
                meta_addr     = pfn_reg;
                meta_we       = 1'b1;
                meta_wdata    = '{kind: KIND_ALLOC_HEAD, blk_order: ord_reg,
                                  next_link: LINK_NONE, prev_link: LINK_NONE};
                fin_page_next = pfn_reg;
                fin_ord_next  = ord_reg;
                st_next       = S_DONE;
            end

            // free: check head, then merge one level per pass
            S_F_CHK:
            begin
                if (meta_rd_reg.kind != KIND_ALLOC_HEAD ||
                    meta_rd_reg.blk_order > ORDER_W'(TOP_ORDER))
                begin
                    fin_stat_next = ST_IGNORED;
                    st_next       = S_DONE;
                end
                else
                begin
                    cur_next = meta_rd_reg.blk_order;
                    st_next  = S_M_TEST;
                end
            end
            S_M_TEST:
            begin
                if (cur_reg < ORDER_W'(TOP_ORDER) && {1'b0, bud_c} < managed)
                begin
                    meta_addr = bud_c;
                    bud_next  = bud_c;
                    st_next   = S_M_CHK;
                end
                else
                begin
                    st_next = S_M_EXIT;
                end
            end
            S_M_CHK:
            begin
                if (meta_rd_reg.kind == KIND_FREE_HEAD && meta_rd_reg.blk_order == cur_reg)
                begin
                    tgt_next = bud_reg;
                    ret_next = S_M_JOIN;
                    st_next  = S_U_RD;
                end
                else
                begin
                    st_next = S_M_EXIT;
                end
            end
            S_M_JOIN:
            begin
                // the upper of the two heads becomes an inner page
                meta_addr  = (bud_reg > pfn_reg) ? bud_reg : pfn_reg;
                meta_we    = 1'b1;
                meta_wdata = '{kind: KIND_FREE_TAIL, blk_order: '0,
                               next_link: LINK_NONE, prev_link: LINK_NONE};
                if (bud_reg < pfn_reg)
                begin
                    pfn_next = bud_reg;
                end
                cur_next = cur_reg + 1'b1;
                st_next  = S_M_TEST;
            end
            S_M_EXIT:
            begin
                ppg_next = pfn_reg;
                ret_next = S_M_DONE;
                st_next  = S_P_WR;
            end
            S_M_DONE:
            begin
                fin_page_next = pfn_reg;
                fin_ord_next  = cur_reg;
                st_next       = S_DONE;
            end

            // reserve: one page per cycle
            S_RSV:
            begin
                res_we    = 1'b1;
                res_wdata = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg + 1'b1 >= end_reg)
                begin
                    st_next = S_DONE;
                end
            end

            // build: scan from cursor, cut at first reserved page
            S_B_START:
            begin
                if (s_reg >= managed)
                begin
                    st_next = S_DONE;
                end
                else
                begin
                    fit_next = fit_c;
                    end_next = s_reg + (LINK_W'(1) << fit_c);
                    idx_next = s_reg;
                    st_next  = S_B_SCAN;
                end
            end
            S_B_SCAN:
            begin
                meta_addr  = idx_reg[PAGE_W-1:0];
                meta_we    = 1'b1;
                meta_wdata = '{kind: KIND_USED, blk_order: '0,
                               next_link: LINK_NONE, prev_link: LINK_NONE};
                st_next    = S_B_CHK;
            end
            S_B_CHK:
            begin
                if (res_rd_reg)
                begin
                    if (idx_reg == s_reg)
                    begin
                        s_next  = s_reg + 1'b1;
                        st_next = S_B_START;
                    end
                    else
                    begin
                        cur_next = split_o;
                        ppg_next = s_reg[PAGE_W-1:0];
                        s_next   = s_reg + (LINK_W'(1) << split_o);
                        ret_next = S_B_START;
                        st_next  = S_P_WR;
                    end
                end
                else if (idx_reg + 1'b1 == end_reg)
                begin
                    cur_next = fit_reg;
                    ppg_next = s_reg[PAGE_W-1:0];
                    s_next   = end_reg;
                    ret_next = S_B_START;
                    st_next  = S_P_WR;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    st_next  = S_B_SCAN;
                end
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // metadata memory
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_addr] <= meta_wdata;
        end
        meta_rd_reg <= meta_mem[meta_addr];
    end

    // reserved map memory
    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_addr] <= res_wdata;
        end
        res_rd_reg <= res_mem[res_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            piu_reg       <= LINK_W'(NUM_PAGES);
            for (int o = 0; o < NUM_LISTS; o++)
            begin
                first_reg[o] <= LINK_NONE;
                last_reg[o]  <= LINK_NONE;
            end
        end
        else
        begin
            st_reg        <= st_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            if (cfg_wr_en)
            begin
                piu_reg <= cfg_wr_data;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        ret_reg      <= ret_next;
        cur_reg      <= cur_next;
        ord_reg      <= ord_next;
        fit_reg      <= fit_next;
        pfn_reg      <= pfn_next;
        bud_reg      <= bud_next;
        tgt_reg      <= tgt_next;
        ppg_reg      <= ppg_next;
        pv_reg       <= pv_next;
        nx_reg       <= nx_next;
        end_reg      <= end_next;
        s_reg        <= s_next;
        fin_stat_reg <= fin_stat_next;
        fin_page_reg <= fin_page_next;
        fin_ord_reg  <= fin_ord_next;
        if (out_load)
        begin
            out_stat_reg <= fin_stat_reg;
            out_page_reg <= fin_page_reg;
            out_ord_reg  <= fin_ord_reg;
        end
    end

    assign s_axis_tready = (st_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_ord_reg, out_page_reg, out_stat_reg};

endmodule

`default_nettype wire

/* rtl/core/bpa_checker.sv */
// bpa_checker: port level assertions for the buddy page allocator core
// depends on bpa_pkg; bound to buddy_page_allocator_core below
`default_nettype none

module bpa_checker
    import bpa_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // one request word in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    // a failed request carries no page and no order
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[17:2] == '0)
        else $error("failed result carries payload");

    // a new result only appears after the core was busy
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a finished request");

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
